@@ rtl/sbwf_pkg.sv @@
// Shared types and constants for the square-wave beep generator with fade.
`timescale 1ns / 1ps

package sbwf_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_PAR,
        ST_MAG,
        ST_EMIT
    } t_state;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_SAMPLE_RATE   = 3'd0,
        CFG_HALF_PERIOD   = 3'd1,
        CFG_FADE_LENGTH   = 3'd2,
        CFG_AMPLITUDE     = 3'd3,
        CFG_DEFAULT_TICKS = 3'd4,
        CFG_MAX_TICKS     = 3'd5
    } t_cfg_index;

    // Input item kinds carried in tuser.
    localparam logic ACT_ADVANCE = 1'b0;
    localparam logic ACT_START   = 1'b1;

    // Register reset values.
    localparam logic [16:0] RST_SAMPLE_RATE   = 17'd48000;
    localparam logic [15:0] RST_HALF_PERIOD   = 16'd32;
    localparam logic [15:0] RST_FADE_LENGTH   = 16'd192;
    localparam logic [14:0] RST_AMPLITUDE     = 15'd8192;
    localparam logic [5:0]  RST_DEFAULT_TICKS = 6'd30;
    localparam logic [5:0]  RST_MAX_TICKS     = 6'd60;

    // Ticks per second and the longest beep in samples.
    localparam logic [15:0] TICKS_PER_SEC = 16'd60;
    localparam logic [16:0] LEN_MAX       = 17'h1FFFF;

    // Divider dividend width and the step count of each division.
    localparam int DVD_W = 31;
    localparam logic [4:0] PAR_STEPS = 5'd17;
    localparam logic [4:0] LEN_STEPS = 5'd23;
    localparam logic [4:0] MAG_STEPS = 5'd31;

endpackage

@@ rtl/square_beep_with_fade.sv @@
// Square-wave beep generator with a linear fade at both ends.
`timescale 1ns / 1ps
//
// Usage: items enter on the s_axis channel. tuser = 1 starts a beep whose
// length in sixtieths of a second is in tdata (zero selects the default,
// longer requests are clamped); tuser = 0 advances one sample tick. Every
// advance gives one transfer on m_axis: the signed sample in tdata, the
// playing flag in tuser, and tlast on the last sample of a beep. A start
// gives no result. A start that arrives while a beep sounds is held in one
// pending slot and plays right after the current beep; further starts are
// dropped until the slot empties.
// All divisions run through one restoring divider, one quotient bit per
// cycle. A start divides sample rate times ticks by 60 for the length. An
// advance while playing divides the position by the half period for the
// square-wave phase and, in a fade ramp, the scaled amplitude by the ramp
// length. An idle advance needs no divide. A pending start runs its length
// divide after the current beep's last sample. s_axis_tready is high only
// while the sequencer is idle. Results wait in an output register, so a
// stalled receiver delays the block only when a second result is ready.
// Reset (synchronous, active low) stops any beep, empties the pending slot
// and restores the register defaults. Configuration writes are always ready.

module square_beep_with_fade (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] duration
    input  logic        s_axis_tuser,    // [0] action
    // Result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,    // [15:0] sample (signed)
    output logic        m_axis_tuser,    // [0] playing
    output logic        m_axis_tlast,    // last_sample
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    // Configuration registers.
    logic [16:0] r_sample_rate;
    logic [15:0] r_half_period;
    logic [15:0] r_fade_length;
    logic [14:0] r_amplitude;
    logic [5:0]  r_default_ticks;
    logic [5:0]  r_max_ticks;

    // Sequencer and beep state.
    sbwf_pkg::t_state r_state, n_state;
    logic [16:0] r_pos, n_pos;
    logic [16:0] r_beep, n_beep;
    logic [15:0] r_ramp, n_ramp;
    logic        r_busy, n_busy;
    logic        r_pend_valid, n_pend_valid;
    logic [5:0]  r_pend_ticks, n_pend_ticks;

    // Shared divider: dividend shifts out at the top while quotient bits
    // shift in at the bottom.
    logic [sbwf_pkg::DVD_W-1:0] r_dvd, n_dvd;
    logic [15:0] r_rem, n_rem;
    logic [15:0] r_dsr, n_dsr;
    logic [4:0]  r_cnt, n_cnt;

    // Working values of the current advance.
    logic        r_fade, n_fade;
    logic [15:0] r_fade_k, n_fade_k;
    logic        r_sign, n_sign;
    logic [14:0] r_mag, n_mag;
    logic        r_play, n_play;
    logic        r_last, n_last;

    // Output register.
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out_data, n_out_data;
    logic        r_out_user, n_out_user;
    logic        r_out_last, n_out_last;

    logic        s_fire;
    logic [15:0] req_ticks;
    logic [5:0]  res_ticks;
    logic [5:0]  launch_ticks;
    logic [22:0] len_prod;
    logic [30:0] mag_prod;
    logic [16:0] trial_in;
    logic [16:0] trial;
    logic        trial_ge;
    logic [16:0] len_sat;
    logic [15:0] len_half;
    logic [16:0] pos_inc;
    logic [16:0] ramp_start;
    logic        fade_up;
    logic        fade_dn;
    logic [15:0] hp_eff;

    assign s_axis_tready = (r_state == sbwf_pkg::ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tlast  = r_out_last;

    // Resolve the requested ticks: zero picks the default, then clamp.
    assign req_ticks = (s_axis_tdata != 16'd0) ? s_axis_tdata : {10'd0, r_default_ticks};
    assign res_ticks = (req_ticks > {10'd0, r_max_ticks}) ? r_max_ticks : req_ticks[5:0];

    // One multiplier feeds the length divide, another the fade divide.
    assign launch_ticks = (r_state == sbwf_pkg::ST_IDLE) ? res_ticks : r_pend_ticks;
    assign len_prod     = {6'd0, r_sample_rate} * {17'd0, launch_ticks};
    assign mag_prod     = {16'd0, r_amplitude} * {15'd0, r_fade_k};

    // One restoring divide step.
    assign trial_in = {r_rem, r_dvd[sbwf_pkg::DVD_W-1]};
    assign trial    = trial_in - {1'b0, r_dsr};
    assign trial_ge = (trial_in >= {1'b0, r_dsr});

    // Length quotient saturates at the widest beep.
    assign len_sat  = (|r_dvd[22:17]) ? sbwf_pkg::LEN_MAX : r_dvd[16:0];
    assign len_half = len_sat[16:1];

    assign pos_inc    = r_pos + 17'd1;
    assign ramp_start = r_beep - {1'b0, r_ramp};
    assign fade_up    = (r_ramp != 16'd0) && (r_pos < {1'b0, r_ramp});
    assign fade_dn    = (r_ramp != 16'd0) && (r_pos >= ramp_start);
    assign hp_eff     = (r_half_period != 16'd0) ? r_half_period : 16'd1;

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_beep       = r_beep;
        n_ramp       = r_ramp;
        n_busy       = r_busy;
        n_pend_valid = r_pend_valid;
        n_pend_ticks = r_pend_ticks;
        n_dvd        = r_dvd;
        n_rem        = r_rem;
        n_dsr        = r_dsr;
        n_cnt        = r_cnt;
        n_fade       = r_fade;
        n_fade_k     = r_fade_k;
        n_sign       = r_sign;
        n_mag        = r_mag;
        n_play       = r_play;
        n_last       = r_last;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_data   = r_out_data;
        n_out_user   = r_out_user;
        n_out_last   = r_out_last;

        // Divider step while iterations remain.
        if (r_cnt != 5'd0) begin
            n_dvd = {r_dvd[sbwf_pkg::DVD_W-2:0], trial_ge};
            n_rem = trial_ge ? trial[15:0] : trial_in[15:0];
            n_cnt = r_cnt - 5'd1;
        end

        unique case (r_state)
            sbwf_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser == sbwf_pkg::ACT_START) begin
                        if (res_ticks != 6'd0) begin
                            if (!r_busy) begin
                                n_dvd   = {len_prod, 8'd0};
                                n_rem   = 16'd0;
                                n_dsr   = sbwf_pkg::TICKS_PER_SEC;
                                n_cnt   = sbwf_pkg::LEN_STEPS;
                                n_state = sbwf_pkg::ST_LEN;
                            end else if (!r_pend_valid) begin
                                n_pend_valid = 1'b1;
                                n_pend_ticks = res_ticks;
                            end
                        end
                    end else if (!r_busy) begin
                        n_play  = 1'b0;
                        n_sign  = 1'b0;
                        n_mag   = 15'd0;
                        n_last  = 1'b0;
                        n_state = sbwf_pkg::ST_EMIT;
                    end else begin
                        n_dvd    = {r_pos, 14'd0};
                        n_rem    = 16'd0;
                        n_dsr    = hp_eff;
                        n_cnt    = sbwf_pkg::PAR_STEPS;
                        n_fade   = fade_up || fade_dn;
                        n_fade_k = fade_up ? r_pos[15:0] : 16'(r_beep - r_pos);
                        n_state  = sbwf_pkg::ST_PAR;
                    end
                end
            end
            sbwf_pkg::ST_LEN: begin
                if (r_cnt == 5'd0) begin
                    if (len_sat != 17'd0) begin
                        n_beep = len_sat;
                        n_ramp = (r_fade_length < len_half) ? r_fade_length : len_half;
                        n_pos  = 17'd0;
                        n_busy = 1'b1;
                    end
                    n_state = sbwf_pkg::ST_IDLE;
                end
            end
            sbwf_pkg::ST_PAR: begin
                if (r_cnt == 5'd0) begin
                    n_play = 1'b1;
                    n_sign = r_dvd[0];
                    n_last = ({1'b0, r_pos} + 18'd1) == {1'b0, r_beep};
                    if (r_fade) begin
                        n_dvd   = mag_prod;
                        n_rem   = 16'd0;
                        n_dsr   = r_ramp;
                        n_cnt   = sbwf_pkg::MAG_STEPS;
                        n_state = sbwf_pkg::ST_MAG;
                    end else begin
                        n_mag   = r_amplitude;
                        n_state = sbwf_pkg::ST_EMIT;
                    end
                end
            end
            sbwf_pkg::ST_MAG: begin
                if (r_cnt == 5'd0) begin
                    n_mag   = r_dvd[14:0];
                    n_state = sbwf_pkg::ST_EMIT;
                end
            end
            sbwf_pkg::ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_user  = r_play;
                    n_out_last  = r_last;
                    if (!r_play) begin
                        n_out_data = 16'd0;
                    end else if (r_sign) begin
                        n_out_data = {1'b0, r_mag};
                    end else begin
                        n_out_data = 16'd0 - {1'b0, r_mag};
                    end
                    n_state = sbwf_pkg::ST_IDLE;
                    if (r_play) begin
                        if (pos_inc >= r_beep) begin
                            n_busy = 1'b0;
                            n_pos  = 17'd0;
                            if (r_pend_valid) begin
                                n_pend_valid = 1'b0;
                                n_pend_ticks = 6'd0;
                                n_dvd        = {len_prod, 8'd0};
                                n_rem        = 16'd0;
                                n_dsr        = sbwf_pkg::TICKS_PER_SEC;
                                n_cnt        = sbwf_pkg::LEN_STEPS;
                                n_state      = sbwf_pkg::ST_LEN;
                            end
                        end else begin
                            n_pos = pos_inc;
                        end
                    end
                end
            end
            default: begin
                n_state = sbwf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sbwf_pkg::ST_IDLE;
            r_pos        <= 17'd0;
            r_beep       <= 17'd0;
            r_ramp       <= 16'd0;
            r_busy       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_ticks <= 6'd0;
            r_cnt        <= 5'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_pos        <= n_pos;
            r_beep       <= n_beep;
            r_ramp       <= n_ramp;
            r_busy       <= n_busy;
            r_pend_valid <= n_pend_valid;
            r_pend_ticks <= n_pend_ticks;
            r_cnt        <= n_cnt;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_dvd      <= n_dvd;
        r_rem      <= n_rem;
        r_dsr      <= n_dsr;
        r_fade     <= n_fade;
        r_fade_k   <= n_fade_k;
        r_sign     <= n_sign;
        r_mag      <= n_mag;
        r_play     <= n_play;
        r_last     <= n_last;
        r_out_data <= n_out_data;
        r_out_user <= n_out_user;
        r_out_last <= n_out_last;
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate   <= sbwf_pkg::RST_SAMPLE_RATE;
            r_half_period   <= sbwf_pkg::RST_HALF_PERIOD;
            r_fade_length   <= sbwf_pkg::RST_FADE_LENGTH;
            r_amplitude     <= sbwf_pkg::RST_AMPLITUDE;
            r_default_ticks <= sbwf_pkg::RST_DEFAULT_TICKS;
            r_max_ticks     <= sbwf_pkg::RST_MAX_TICKS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                sbwf_pkg::CFG_SAMPLE_RATE:   r_sample_rate   <= i_cfg_data;
                sbwf_pkg::CFG_HALF_PERIOD:   r_half_period   <= i_cfg_data[15:0];
                sbwf_pkg::CFG_FADE_LENGTH:   r_fade_length   <= i_cfg_data[15:0];
                sbwf_pkg::CFG_AMPLITUDE:     r_amplitude     <= i_cfg_data[14:0];
                sbwf_pkg::CFG_DEFAULT_TICKS: r_default_ticks <= i_cfg_data[5:0];
                sbwf_pkg::CFG_MAX_TICKS:     r_max_ticks     <= i_cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

endmodule
